// ===== rtl/bsm_pkg.sv =====
// Shared constants, codes and the result record of the bencode span matcher.
`default_nettype none
package bsm_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int POS_BITS    = 32;
  localparam int LEN_W       = 32;
  localparam int SPAN_W      = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int FIFO_DEPTH  = 4;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK,
    ST_UNMATCHED,
    ST_UNCLOSED,
    ST_BAD_BYTE,
    ST_BAD_LEN,
    ST_TRUNCATED,
    ST_STACK_OVF,
    ST_LEN_OVF
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    status_t           status;
    logic              final_flag;
  } rslt_t;

endpackage
`default_nettype wire

// ===== rtl/bsm_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and hands out one.
`default_nettype none
module bsm_result_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_cnt,
  input  wire bsm_pkg::rslt_t push_a,
  input  wire bsm_pkg::rslt_t push_b,
  input  wire logic          pop,
  output bsm_pkg::rslt_t     head,
  output logic               not_empty,
  output logic               room2
);

  bsm_pkg::rslt_t mem_r [bsm_pkg::FIFO_DEPTH];
  logic [bsm_pkg::FPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_b;
  logic [bsm_pkg::FCNT_W-1:0] cnt_r, cnt_nxt;

  assign wp_b      = wp_r + bsm_pkg::FPTR_W'(1);
  assign head      = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= bsm_pkg::FCNT_W'(bsm_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + bsm_pkg::FPTR_W'(push_cnt);
    rp_nxt  = rp_r + bsm_pkg::FPTR_W'(pop);
    cnt_nxt = cnt_r + bsm_pkg::FCNT_W'(push_cnt) - bsm_pkg::FCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= push_a;
    if (push_cnt == 2'd2) mem_r[wp_b] <= push_b;
  end

endmodule
`default_nettype wire

// ===== rtl/bencode_span_matcher_top.sv =====
// Top level of the bencode span matcher: byte scanner, open-container stack, result queue.
// Latency: a byte's results enter the result queue at its accept edge and, behind older
//   results, go out from the next cycle; a last byte closing a token gives two in a row.
// Throughput: one byte per cycle; input stalls only while the queue has under two free slots.
// Reset: synchronous, active low; clears position, mode, counters, error and the queue.
//   The stack memory is not cleared: an unwritten entry reaches only an unused below_r.
`default_nettype none
module bencode_span_matcher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [31:0]      out_span_start,
  output logic [31:0]      out_span_end,
  output logic [2:0]       out_status,
  output logic             out_final_flag
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_LEN,
    MODE_BODY
  } mode_t;

  localparam int POS_BITS = bsm_pkg::POS_BITS;
  localparam int LEN_W    = bsm_pkg::LEN_W;
  localparam int CNT_W    = bsm_pkg::CNT_W;
  localparam int IDX_W    = bsm_pkg::IDX_W;
  localparam int SPAN_W   = bsm_pkg::SPAN_W;

  // scanner state
  mode_t                mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  begin_r, begin_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  bsm_pkg::status_t     err_r, err_nxt;

  // stack: top_r caches entry cnt-1, below_r caches entry cnt-2, memory holds 0..cnt-2
  logic [POS_BITS-1:0]  stack_mem [bsm_pkg::STACK_DEPTH];
  logic [POS_BITS-1:0]  top_r, below_r;
  logic [IDX_W-1:0]     wr_idx, rd_idx;
  logic                 push_en, pop_en;

  // result queue hookup
  logic                 accept, pop_out;
  logic                 span_vld;
  logic [1:0]           push_cnt;
  bsm_pkg::rslt_t       span_res, stat_res, push_a, push_b, head;
  bsm_pkg::status_t     final_st;
  logic                 not_empty, room2;

  logic                 digit;
  logic [3:0]           digit_val;
  logic [LEN_W+3:0]     len_x10;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !room2;
  assign pop_out   = not_empty && !out_stall;
  assign out_valid = not_empty;

  assign digit     = (in_byte_value >= bsm_pkg::CH_ZERO) && (in_byte_value <= bsm_pkg::CH_NINE);
  assign digit_val = 4'(in_byte_value - bsm_pkg::CH_ZERO);
  // accum * 10 + digit as (x << 3) + (x << 1) + d
  assign len_x10   = ({4'd0, len_r} << 3) + ({4'd0, len_r} << 1) + (LEN_W+4)'(digit_val);

  // index of the old top when it moves into memory, and of the new below after a pop
  assign wr_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign rd_idx = IDX_W'(cnt_r - CNT_W'(3));

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    begin_nxt = begin_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    span_vld  = 1'b0;
    span_res.kind       = 1'b0;
    span_res.span_start = SPAN_W'(begin_r);
    span_res.span_end   = SPAN_W'(pos_r);
    span_res.status     = bsm_pkg::ST_OK;
    span_res.final_flag = !in_last_byte;

    if (accept) begin
      pos_nxt = pos_r + POS_BITS'(1);
      if (err_r == bsm_pkg::ST_OK) begin
        unique case (mode_r)
          MODE_IDLE: begin
            priority if (in_byte_value == bsm_pkg::CH_E) begin
              if (cnt_r != '0) begin
                pop_en              = 1'b1;
                cnt_nxt             = cnt_r - CNT_W'(1);
                span_vld            = 1'b1;
                span_res.span_start = SPAN_W'(top_r);
              end else begin
                err_nxt = bsm_pkg::ST_UNMATCHED;
              end
            end else if (in_byte_value == bsm_pkg::CH_L || in_byte_value == bsm_pkg::CH_D) begin
              if (cnt_r >= CNT_W'(bsm_pkg::STACK_DEPTH)) begin
                err_nxt = bsm_pkg::ST_STACK_OVF;
              end else begin
                push_en = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end else if (in_byte_value == bsm_pkg::CH_I) begin
              begin_nxt = pos_r;
              mode_nxt  = MODE_INT;
            end else if (digit) begin
              begin_nxt = pos_r;
              len_nxt   = LEN_W'(digit_val);
              mode_nxt  = MODE_LEN;
            end else begin
              err_nxt = bsm_pkg::ST_BAD_BYTE;
            end
          end
          MODE_INT: begin
            if (in_byte_value == bsm_pkg::CH_E) begin
              span_vld = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_LEN: begin
            priority if (digit) begin
              len_nxt = len_x10[LEN_W-1:0];
              if (len_x10[LEN_W+3:LEN_W] != 4'd0) err_nxt = bsm_pkg::ST_LEN_OVF;
            end else if (in_byte_value == bsm_pkg::CH_COLON) begin
              if (len_r == '0) begin
                // empty string closes on its colon
                span_vld = 1'b1;
                mode_nxt = MODE_IDLE;
              end else begin
                rem_nxt  = len_r;
                mode_nxt = MODE_BODY;
              end
            end else begin
              err_nxt = bsm_pkg::ST_BAD_LEN;
            end
          end
          MODE_BODY: begin
            if (rem_r != '0) rem_nxt = rem_r - LEN_W'(1);
            if (rem_r <= LEN_W'(1)) begin
              span_vld = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
    end

    // final status looks at the state this byte leaves behind
    priority if (err_nxt != bsm_pkg::ST_OK) final_st = err_nxt;
    else if (mode_nxt != MODE_IDLE)          final_st = bsm_pkg::ST_TRUNCATED;
    else if (cnt_nxt != '0)                  final_st = bsm_pkg::ST_UNCLOSED;
    else                                     final_st = bsm_pkg::ST_OK;

    stat_res.kind       = 1'b1;
    stat_res.span_start = '0;
    stat_res.span_end   = '0;
    stat_res.status     = final_st;
    stat_res.final_flag = 1'b1;

    // end of message: drop all scanner state, next byte starts at position zero
    if (accept && in_last_byte) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      begin_nxt = '0;
      len_nxt   = '0;
      rem_nxt   = '0;
      cnt_nxt   = '0;
      err_nxt   = bsm_pkg::ST_OK;
    end

    push_cnt = 2'(accept && span_vld) + 2'(accept && in_last_byte);
    push_a   = span_vld ? span_res : stat_res;
    push_b   = stat_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
      err_r   <= bsm_pkg::ST_OK;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  // stack storage: push spills the old top into memory, pop refills below_r from memory
  always_ff @(posedge clk) begin
    if (push_en && cnt_r != '0) stack_mem[wr_idx] <= top_r;
    if (push_en) begin
      top_r   <= pos_r;
      below_r <= top_r;
    end else if (pop_en) begin
      top_r   <= below_r;
      below_r <= stack_mem[rd_idx];
    end
  end

  bsm_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (push_b),
    .pop       (pop_out),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_kind       = head.kind;
  assign out_span_start = head.span_start;
  assign out_span_end   = head.span_end;
  assign out_status     = head.status;
  assign out_final_flag = head.final_flag;

  // a last byte returns the scanner to its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> pos_r == '0 && cnt_r == '0 && mode_r == MODE_IDLE &&
                               err_r == bsm_pkg::ST_OK)
    else $error("scanner state not cleared after last byte");

  // once an error is latched, bytes before the last give no result and leave the stack
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_last_byte && err_r != bsm_pkg::ST_OK |-> push_cnt == 2'd0 && !push_en && !pop_en)
    else $error("activity after latched error");

  // a push inside a message grows the stack by one and never past its depth
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push_en && !in_last_byte |=> cnt_r <= CNT_W'(bsm_pkg::STACK_DEPTH) &&
                                 cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("stack count out of step with push");

endmodule
`default_nettype wire
